@@ src/rtsc_pkg.sv @@
// Shared types and constants for the RTS/CTS link handshake controller.
package rtsc_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_PKT  = 2'd1;
    localparam logic [1:0] FUNC_SEND = 2'd2;

    // Packet type codes on the air.
    localparam logic [7:0] PKT_RTS   = 8'h01;
    localparam logic [7:0] PKT_CTS   = 8'h02;
    localparam logic [7:0] PKT_DATA  = 8'h03;
    localparam logic [7:0] PKT_ACK   = 8'h04;
    localparam logic [7:0] PKT_RETRY = 8'h06;

    localparam logic [2:0] TX_NONE = 3'd0;
    localparam logic [2:0] TX_RTS  = 3'd1;
    localparam logic [2:0] TX_CTS  = 3'd2;
    localparam logic [2:0] TX_DATA = 3'd3;
    localparam logic [2:0] TX_ACK  = 3'd4;

    localparam logic [7:0] MIN_RX_LEN = 8'd8;

    // Phase codes as reported in state_code.
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_ISSUE_RTS = 4'd1;
    localparam logic [3:0] PH_WAIT_CTS  = 4'd2;
    localparam logic [3:0] PH_SEND_DATA = 4'd3;
    localparam logic [3:0] PH_WAIT_ACK  = 4'd4;
    localparam logic [3:0] PH_SUCCESS   = 4'd5;
    localparam logic [3:0] PH_SEND_CTS  = 4'd6;
    localparam logic [3:0] PH_WAIT_DATA = 4'd7;
    localparam logic [3:0] PH_SEND_ACK  = 4'd8;
    localparam logic [3:0] PH_RETRY     = 4'd9;
    localparam logic [3:0] PH_ERROR     = 4'd10;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OWN_USER  = 3'd0;
    localparam logic [2:0] CFG_OWN_NODE  = 3'd1;
    localparam logic [2:0] CFG_PEER_USER = 3'd2;
    localparam logic [2:0] CFG_PEER_NODE = 3'd3;
    localparam logic [2:0] CFG_MAX_RETRY = 3'd4;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd5;
    localparam logic [2:0] CFG_COOLDOWN  = 3'd6;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef struct packed {
        logic [7:0]  own_user_id;
        logic [7:0]  own_node_id;
        logic [3:0]  max_retries;
        logic [15:0] timeout_ticks;
        logic [15:0] cooldown_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_len;
        logic [7:0] rx_kind;
        logic [7:0] pkt_msg_id;
        logic [7:0] pkt_dst_user;
        logic [7:0] pkt_dst_node;
        logic       crc_ok;
    } item_t;

    typedef struct packed {
        logic [2:0] tx_type;
        logic [7:0] tx_msg_id;
        logic [3:0] state_code;
        logic       request_taken;
        logic       delivered;
        logic       gave_up;
        logic       crc_error;
        logic       data_accepted;
    } result_t;

endpackage

@@ src/rtsc_cfg_regs.sv @@
// Configuration register file for the handshake controller.
module rtsc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rtsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rtsc_pkg::cfg_t                 cfg
);

    rtsc_pkg::cfg_t cfg_reg;

    // Peer ids are not stored here; writes to their indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_user_id    <= 8'd0;
            cfg_reg.own_node_id    <= 8'd0;
            cfg_reg.max_retries    <= 4'd3;
            cfg_reg.timeout_ticks  <= 16'd3000;
            cfg_reg.cooldown_ticks <= 16'd100;
        end else if (cfg_we) begin
            case (cfg_index)
                rtsc_pkg::CFG_OWN_USER:  cfg_reg.own_user_id    <= cfg_wdata[7:0];
                rtsc_pkg::CFG_OWN_NODE:  cfg_reg.own_node_id    <= cfg_wdata[7:0];
                rtsc_pkg::CFG_MAX_RETRY: cfg_reg.max_retries    <= cfg_wdata[3:0];
                rtsc_pkg::CFG_TIMEOUT:   cfg_reg.timeout_ticks  <= cfg_wdata;
                rtsc_pkg::CFG_COOLDOWN:  cfg_reg.cooldown_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/rtsc_fsm.sv @@
// Handshake state machine: link state registers and per-item next-state logic.
module rtsc_fsm (
    input  logic                aclk,
    input  logic                aresetn,
    input  rtsc_pkg::cfg_t      cfg,
    input  logic                step_en,
    input  rtsc_pkg::item_t     item,
    output rtsc_pkg::result_t   result
);

    typedef enum logic [3:0] {
        S_IDLE      = rtsc_pkg::PH_IDLE,
        S_ISSUE_RTS = rtsc_pkg::PH_ISSUE_RTS,
        S_WAIT_CTS  = rtsc_pkg::PH_WAIT_CTS,
        S_SEND_DATA = rtsc_pkg::PH_SEND_DATA,
        S_WAIT_ACK  = rtsc_pkg::PH_WAIT_ACK,
        S_SUCCESS   = rtsc_pkg::PH_SUCCESS,
        S_SEND_CTS  = rtsc_pkg::PH_SEND_CTS,
        S_WAIT_DATA = rtsc_pkg::PH_WAIT_DATA,
        S_SEND_ACK  = rtsc_pkg::PH_SEND_ACK,
        S_RETRY     = rtsc_pkg::PH_RETRY,
        S_ERROR     = rtsc_pkg::PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        cts_seen_reg, cts_seen_next;
    logic        ack_seen_reg, ack_seen_next;
    logic        rts_seen_reg, rts_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic        retry_seen_reg, retry_seen_next;
    logic        link_busy_reg, link_busy_next;
    logic [3:0]  rts_attempts_reg, rts_attempts_next;
    logic [3:0]  data_attempts_reg, data_attempts_next;
    logic [15:0] wait_timer_reg, wait_timer_next;
    logic [15:0] cooldown_reg, cooldown_next;
    logic [7:0]  own_msg_id_reg, own_msg_id_next;
    logic [7:0]  peer_msg_id_reg, peer_msg_id_next;

    logic        timeout_hit;
    logic        clear_chan;
    logic        pkt_for_us;
    logic [15:0] cooldown_dec;
    rtsc_pkg::result_t res;

    assign timeout_hit  = (wait_timer_reg >= cfg.timeout_ticks);
    assign cooldown_dec = (cooldown_reg != 16'd0) ? (cooldown_reg - 16'd1) : cooldown_reg;
    assign pkt_for_us   = (item.rx_len >= rtsc_pkg::MIN_RX_LEN)
                          && (item.pkt_dst_user == cfg.own_user_id)
                          && (item.pkt_dst_node == cfg.own_node_id);

    always_comb begin
        phase_next         = phase_reg;
        cts_seen_next      = cts_seen_reg;
        ack_seen_next      = ack_seen_reg;
        rts_seen_next      = rts_seen_reg;
        data_seen_next     = data_seen_reg;
        retry_seen_next    = retry_seen_reg;
        link_busy_next     = link_busy_reg;
        rts_attempts_next  = rts_attempts_reg;
        data_attempts_next = data_attempts_reg;
        wait_timer_next    = wait_timer_reg;
        cooldown_next      = cooldown_reg;
        own_msg_id_next    = own_msg_id_reg;
        peer_msg_id_next   = peer_msg_id_reg;
        clear_chan         = 1'b0;
        res                = '0;

        if (step_en) begin
            case (item.func)
                rtsc_pkg::FUNC_TICK: begin
                    cooldown_next = cooldown_dec;
                    case (phase_reg)
                        S_IDLE: begin
                            if (cooldown_dec == 16'd0 && rts_seen_reg) begin
                                rts_seen_next = 1'b0;
                                phase_next    = S_SEND_CTS;
                            end
                        end
                        S_ISSUE_RTS: begin
                            res.tx_type     = rtsc_pkg::TX_RTS;
                            res.tx_msg_id   = own_msg_id_reg;
                            wait_timer_next = 16'd0;
                            phase_next      = S_WAIT_CTS;
                        end
                        S_WAIT_CTS: begin
                            if (cts_seen_reg) begin
                                cts_seen_next = 1'b0;
                                phase_next    = S_SEND_DATA;
                            end else if (!timeout_hit) begin
                                wait_timer_next = wait_timer_reg + 16'd1;
                            end else if (rts_attempts_reg < cfg.max_retries) begin
                                rts_attempts_next = rts_attempts_reg + 4'd1;
                                phase_next        = S_ISSUE_RTS;
                            end else begin
                                clear_chan  = 1'b1;
                                phase_next  = S_IDLE;
                                res.gave_up = 1'b1;
                            end
                        end
                        S_SEND_DATA: begin
                            res.tx_type     = rtsc_pkg::TX_DATA;
                            res.tx_msg_id   = own_msg_id_reg;
                            wait_timer_next = 16'd0;
                            phase_next      = S_WAIT_ACK;
                        end
                        S_WAIT_ACK: begin
                            // ACK and timeout override a pending peer retry
                            if (retry_seen_reg) begin
                                phase_next = S_RETRY;
                            end
                            if (ack_seen_reg) begin
                                ack_seen_next = 1'b0;
                                phase_next    = S_SUCCESS;
                            end else if (!timeout_hit) begin
                                wait_timer_next = wait_timer_reg + 16'd1;
                            end else if (data_attempts_reg < cfg.max_retries) begin
                                data_attempts_next = data_attempts_reg + 4'd1;
                                phase_next         = S_SEND_DATA;
                            end else begin
                                clear_chan  = 1'b1;
                                phase_next  = S_IDLE;
                                res.gave_up = 1'b1;
                            end
                        end
                        S_SUCCESS: begin
                            own_msg_id_next = own_msg_id_reg + 8'd1;
                            cooldown_next   = cfg.cooldown_ticks;
                            clear_chan      = 1'b1;
                            phase_next      = S_IDLE;
                            res.delivered   = 1'b1;
                        end
                        S_SEND_CTS: begin
                            res.tx_type     = rtsc_pkg::TX_CTS;
                            res.tx_msg_id   = peer_msg_id_reg;
                            wait_timer_next = 16'd0;
                            phase_next      = S_WAIT_DATA;
                        end
                        S_WAIT_DATA: begin
                            if (data_seen_reg) begin
                                data_seen_next = 1'b0;
                                phase_next     = S_SEND_ACK;
                            end else if (!timeout_hit) begin
                                wait_timer_next = wait_timer_reg + 16'd1;
                            end else begin
                                clear_chan  = 1'b1;
                                phase_next  = S_IDLE;
                                res.gave_up = 1'b1;
                            end
                        end
                        S_SEND_ACK: begin
                            res.tx_type   = rtsc_pkg::TX_ACK;
                            res.tx_msg_id = peer_msg_id_reg;
                            clear_chan    = 1'b1;
                            phase_next    = S_IDLE;
                        end
                        S_RETRY: begin
                            if (retry_seen_reg) begin
                                retry_seen_next = 1'b0;
                                phase_next      = S_SEND_DATA;
                            end
                        end
                        S_ERROR: begin
                            // keep wait_timer running from where it was
                            phase_next = S_WAIT_DATA;
                        end
                        default: begin
                            phase_next = S_IDLE;
                        end
                    endcase
                end
                rtsc_pkg::FUNC_PKT: begin
                    if (pkt_for_us) begin
                        case (item.rx_kind)
                            rtsc_pkg::PKT_RTS: begin
                                if (!link_busy_reg) begin
                                    peer_msg_id_next = item.pkt_msg_id;
                                    rts_seen_next    = 1'b1;
                                end
                            end
                            rtsc_pkg::PKT_CTS: begin
                                cts_seen_next = 1'b1;
                            end
                            rtsc_pkg::PKT_DATA: begin
                                peer_msg_id_next = item.pkt_msg_id;
                                if (item.crc_ok) begin
                                    data_seen_next    = 1'b1;
                                    res.data_accepted = 1'b1;
                                end else begin
                                    phase_next    = S_ERROR;
                                    res.crc_error = 1'b1;
                                end
                            end
                            rtsc_pkg::PKT_ACK: begin
                                if (item.pkt_msg_id == own_msg_id_reg) begin
                                    ack_seen_next = 1'b1;
                                end
                            end
                            rtsc_pkg::PKT_RETRY: begin
                                if (item.pkt_msg_id == own_msg_id_reg) begin
                                    retry_seen_next = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                rtsc_pkg::FUNC_SEND: begin
                    if (!link_busy_reg && phase_reg == S_IDLE) begin
                        link_busy_next    = 1'b1;
                        phase_next        = S_ISSUE_RTS;
                        res.request_taken = 1'b1;
                    end
                end
                default: ;
            endcase

            // retry_seen survives a channel clear
            if (clear_chan) begin
                cts_seen_next      = 1'b0;
                ack_seen_next      = 1'b0;
                rts_seen_next      = 1'b0;
                data_seen_next     = 1'b0;
                link_busy_next     = 1'b0;
                rts_attempts_next  = 4'd0;
                data_attempts_next = 4'd0;
            end
        end

        res.state_code = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= S_IDLE;
            cts_seen_reg      <= 1'b0;
            ack_seen_reg      <= 1'b0;
            rts_seen_reg      <= 1'b0;
            data_seen_reg     <= 1'b0;
            retry_seen_reg    <= 1'b0;
            link_busy_reg     <= 1'b0;
            rts_attempts_reg  <= 4'd0;
            data_attempts_reg <= 4'd0;
            wait_timer_reg    <= 16'd0;
            cooldown_reg      <= 16'd0;
            own_msg_id_reg    <= 8'd0;
            peer_msg_id_reg   <= 8'd0;
        end else begin
            phase_reg         <= phase_next;
            cts_seen_reg      <= cts_seen_next;
            ack_seen_reg      <= ack_seen_next;
            rts_seen_reg      <= rts_seen_next;
            data_seen_reg     <= data_seen_next;
            retry_seen_reg    <= retry_seen_next;
            link_busy_reg     <= link_busy_next;
            rts_attempts_reg  <= rts_attempts_next;
            data_attempts_reg <= data_attempts_next;
            wait_timer_reg    <= wait_timer_next;
            cooldown_reg      <= cooldown_next;
            own_msg_id_reg    <= own_msg_id_next;
            peer_msg_id_reg   <= peer_msg_id_next;
        end
    end

    assign result = res;

endmodule

@@ src/rts_cts_link_handshake_core.sv @@
// An item taken on s_ is held in the input register and its result in the result register for m_.
// Throughput: one transaction per cycle unless m_tready holds off; the state update for one
// item is combinational between the input register and the result register.
// Reset: aresetn is synchronous, active low; clears the link state, message ids,
// timers and both valid flags, and loads the configuration register defaults.
// Top level of the RTS/CTS/DATA/ACK link handshake controller.
module rts_cts_link_handshake_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rtsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rx_len, rx_kind, pkt_msg_id, pkt_dst_user, pkt_dst_node, crc_ok, zero pad
    input  logic [47:0]                    s_tdata,
    // func
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tx_type, tx_msg_id, state_code, request_taken, delivered, gave_up,
    // crc_error, data_accepted, zero pad
    output logic [23:0]                    m_tdata
);

    rtsc_pkg::cfg_t    cfg;
    rtsc_pkg::item_t   in_item_reg;
    rtsc_pkg::result_t fsm_result;
    rtsc_pkg::result_t out_res_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              step_en;
    logic              in_take;

    rtsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rtsc_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (step_en),
        .item    (in_item_reg),
        .result  (fsm_result)
    );

    // Advance the held item when the result register is free or draining.
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);
    assign out_valid_next = step_en ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg.func         <= s_tuser;
            in_item_reg.rx_len       <= s_tdata[7:0];
            in_item_reg.rx_kind      <= s_tdata[15:8];
            in_item_reg.pkt_msg_id   <= s_tdata[23:16];
            in_item_reg.pkt_dst_user <= s_tdata[31:24];
            in_item_reg.pkt_dst_node <= s_tdata[39:32];
            in_item_reg.crc_ok       <= s_tdata[40];
        end
        if (step_en) begin
            out_res_reg <= fsm_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_res_reg.data_accepted,
                       out_res_reg.crc_error,
                       out_res_reg.gave_up,
                       out_res_reg.delivered,
                       out_res_reg.request_taken,
                       out_res_reg.state_code,
                       out_res_reg.tx_msg_id,
                       out_res_reg.tx_type};

    a_taken_enters_issue_rts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.request_taken)
            |-> (out_res_reg.state_code == rtsc_pkg::PH_ISSUE_RTS))
        else $error("accepted send request did not move to the RTS issue phase");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0({out_res_reg.request_taken, out_res_reg.delivered,
                               out_res_reg.gave_up, out_res_reg.crc_error,
                               out_res_reg.data_accepted}))
        else $error("more than one event flag in one result");

    a_end_of_link_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_res_reg.delivered || out_res_reg.gave_up))
            |-> (out_res_reg.state_code == rtsc_pkg::PH_IDLE
                 && out_res_reg.tx_type == rtsc_pkg::TX_NONE))
        else $error("delivery or give-up did not return to idle");

    a_crc_error_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.crc_error)
            |-> (out_res_reg.state_code == rtsc_pkg::PH_ERROR))
        else $error("bad CRC did not enter the error phase");

endmodule

@@ tb/sv/tb_rts_cts_link_handshake_core.sv @@
// Self-checking testbench for the RTS/CTS link handshake controller.
`timescale 1ns / 100ps

class link_scoreboard;
    // Configuration
    logic [7:0]  own_user;
    logic [7:0]  own_node;
    logic [7:0]  peer_user;
    logic [7:0]  peer_node;
    logic [3:0]  max_retries;
    logic [15:0] timeout_ticks;
    logic [15:0] cooldown_ticks;

    // Link state
    logic [3:0]  phase;
    bit          cts_seen, ack_seen, rts_seen, data_seen, retry_seen, link_busy;
    logic [3:0]  rts_attempts, data_attempts;
    logic [15:0] wait_timer, cooldown_timer;
    logic [7:0]  own_msg_id, peer_msg_id;

    rtsc_pkg::result_t due_results[$];
    int                errors;

    function new();
        own_user = '0;
        own_node = '0;
        peer_user = '0;
        peer_node = '0;
        max_retries = 4'd3;
        timeout_ticks = 16'd3000;
        cooldown_ticks = 16'd100;
        phase = rtsc_pkg::PH_IDLE;
        retry_seen = 0;
        clear_link();
        wait_timer = '0;
        cooldown_timer = '0;
        own_msg_id = '0;
        peer_msg_id = '0;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            rtsc_pkg::CFG_OWN_USER:  own_user = val[7:0];
            rtsc_pkg::CFG_OWN_NODE:  own_node = val[7:0];
            rtsc_pkg::CFG_PEER_USER: peer_user = val[7:0];
            rtsc_pkg::CFG_PEER_NODE: peer_node = val[7:0];
            rtsc_pkg::CFG_MAX_RETRY: max_retries = val[3:0];
            rtsc_pkg::CFG_TIMEOUT:   timeout_ticks = val;
            rtsc_pkg::CFG_COOLDOWN:  cooldown_ticks = val;
            default: ;
        endcase
    endfunction

    // Retry flag survives a channel clear.
    function void clear_link();
        cts_seen = 0;
        ack_seen = 0;
        rts_seen = 0;
        data_seen = 0;
        link_busy = 0;
        rts_attempts = '0;
        data_attempts = '0;
    endfunction

    // Advance the wait timer unless it has already run out.
    function bit wait_expired();
        if (wait_timer >= timeout_ticks) return 1;
        wait_timer = wait_timer + 16'd1;
        return 0;
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void note_item(rtsc_pkg::item_t it);
        rtsc_pkg::result_t r;
        r = '0;
        case (it.func)
            rtsc_pkg::FUNC_TICK: begin
                if (cooldown_timer != 0) cooldown_timer = cooldown_timer - 16'd1;
                case (phase)
                    rtsc_pkg::PH_IDLE: begin
                        if (cooldown_timer == 0 && rts_seen) begin
                            rts_seen = 0;
                            phase = rtsc_pkg::PH_SEND_CTS;
                        end
                    end
                    rtsc_pkg::PH_ISSUE_RTS: begin
                        r.tx_type = rtsc_pkg::TX_RTS;
                        r.tx_msg_id = own_msg_id;
                        wait_timer = '0;
                        phase = rtsc_pkg::PH_WAIT_CTS;
                    end
                    rtsc_pkg::PH_WAIT_CTS: begin
                        if (cts_seen) begin
                            cts_seen = 0;
                            phase = rtsc_pkg::PH_SEND_DATA;
                        end else if (wait_expired()) begin
                            if (rts_attempts < max_retries) begin
                                rts_attempts = rts_attempts + 4'd1;
                                phase = rtsc_pkg::PH_ISSUE_RTS;
                            end else begin
                                clear_link();
                                phase = rtsc_pkg::PH_IDLE;
                                r.gave_up = 1'b1;
                            end
                        end
                    end
                    rtsc_pkg::PH_SEND_DATA: begin
                        r.tx_type = rtsc_pkg::TX_DATA;
                        r.tx_msg_id = own_msg_id;
                        wait_timer = '0;
                        phase = rtsc_pkg::PH_WAIT_ACK;
                    end
                    rtsc_pkg::PH_WAIT_ACK: begin
                        // ACK and timeout both override a pending peer retry
                        if (retry_seen) phase = rtsc_pkg::PH_RETRY;
                        if (ack_seen) begin
                            ack_seen = 0;
                            phase = rtsc_pkg::PH_SUCCESS;
                        end else if (wait_expired()) begin
                            if (data_attempts < max_retries) begin
                                data_attempts = data_attempts + 4'd1;
                                phase = rtsc_pkg::PH_SEND_DATA;
                            end else begin
                                clear_link();
                                phase = rtsc_pkg::PH_IDLE;
                                r.gave_up = 1'b1;
                            end
                        end
                    end
                    rtsc_pkg::PH_SUCCESS: begin
                        own_msg_id = own_msg_id + 8'd1;
                        cooldown_timer = cooldown_ticks;
                        clear_link();
                        phase = rtsc_pkg::PH_IDLE;
                        r.delivered = 1'b1;
                    end
                    rtsc_pkg::PH_SEND_CTS: begin
                        r.tx_type = rtsc_pkg::TX_CTS;
                        r.tx_msg_id = peer_msg_id;
                        wait_timer = '0;
                        phase = rtsc_pkg::PH_WAIT_DATA;
                    end
                    rtsc_pkg::PH_WAIT_DATA: begin
                        if (data_seen) begin
                            data_seen = 0;
                            phase = rtsc_pkg::PH_SEND_ACK;
                        end else if (wait_expired()) begin
                            clear_link();
                            phase = rtsc_pkg::PH_IDLE;
                            r.gave_up = 1'b1;
                        end
                    end
                    rtsc_pkg::PH_SEND_ACK: begin
                        r.tx_type = rtsc_pkg::TX_ACK;
                        r.tx_msg_id = peer_msg_id;
                        clear_link();
                        phase = rtsc_pkg::PH_IDLE;
                    end
                    rtsc_pkg::PH_RETRY: begin
                        if (retry_seen) begin
                            retry_seen = 0;
                            phase = rtsc_pkg::PH_SEND_DATA;
                        end
                    end
                    rtsc_pkg::PH_ERROR: phase = rtsc_pkg::PH_WAIT_DATA;
                    default:            phase = rtsc_pkg::PH_IDLE;
                endcase
            end
            rtsc_pkg::FUNC_PKT: begin
                if (it.rx_len >= rtsc_pkg::MIN_RX_LEN && it.pkt_dst_user == own_user &&
                    it.pkt_dst_node == own_node) begin
                    case (it.rx_kind)
                        rtsc_pkg::PKT_RTS: begin
                            if (!link_busy) begin
                                peer_msg_id = it.pkt_msg_id;
                                rts_seen = 1;
                            end
                        end
                        rtsc_pkg::PKT_CTS: cts_seen = 1;
                        rtsc_pkg::PKT_DATA: begin
                            peer_msg_id = it.pkt_msg_id;
                            if (it.crc_ok) begin
                                data_seen = 1;
                                r.data_accepted = 1'b1;
                            end else begin
                                phase = rtsc_pkg::PH_ERROR;
                                r.crc_error = 1'b1;
                            end
                        end
                        rtsc_pkg::PKT_ACK:
                            if (it.pkt_msg_id == own_msg_id) ack_seen = 1;
                        rtsc_pkg::PKT_RETRY:
                            if (it.pkt_msg_id == own_msg_id) retry_seen = 1;
                        default: ;
                    endcase
                end
            end
            rtsc_pkg::FUNC_SEND: begin
                if (!link_busy && phase == rtsc_pkg::PH_IDLE) begin
                    link_busy = 1;
                    phase = rtsc_pkg::PH_ISSUE_RTS;
                    r.request_taken = 1'b1;
                end
            end
            default: ;
        endcase
        r.state_code = phase;
        due_results.push_back(r);
    endfunction

    function void compare_field(string fname, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h actual %0h",
                     $time, fname, exp_v, act_v);
        end
    endfunction

    function void check_result(logic [23:0] bus);
        rtsc_pkg::result_t exp_r;
        if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result %h arrived with none expected", $time, bus);
            return;
        end
        exp_r = due_results.pop_front();
        compare_field("tx_type",       exp_r.tx_type,       bus[2:0]);
        compare_field("tx_msg_id",     exp_r.tx_msg_id,     bus[10:3]);
        compare_field("state_code",    exp_r.state_code,    bus[14:11]);
        compare_field("request_taken", exp_r.request_taken, bus[15]);
        compare_field("delivered",     exp_r.delivered,     bus[16]);
        compare_field("gave_up",       exp_r.gave_up,       bus[17]);
        compare_field("crc_error",     exp_r.crc_error,     bus[18]);
        compare_field("data_accepted", exp_r.data_accepted, bus[19]);
    endfunction
endclass

module tb_rts_cts_link_handshake_core;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 400;
    localparam int unsigned STALL_AT = 1000;
    localparam int unsigned STALL_CYCLES = 300;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [rtsc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rtsc_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [47:0]                     s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [23:0]                     m_tdata;

    link_scoreboard sb;
    int unsigned    items_sent = 0;
    int unsigned    cycle_count = 0;
    bit             quiet = 0;
    bit             stall_done = 0;

    rts_cts_link_handshake_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random backpressure plus one long hold-off to fill the block.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!stall_done && items_sent >= STALL_AT) begin
                stall_done = 1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 14);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    function automatic rtsc_pkg::item_t make_item(logic [1:0] f, logic [7:0] kind = 8'd0,
                                                  logic [7:0] id = 8'd0, logic crc = 1'b1,
                                                  logic [7:0] size = 8'd8);
        rtsc_pkg::item_t it;
        it.func = f;
        it.rx_len = size;
        it.rx_kind = kind;
        it.pkt_msg_id = id;
        it.pkt_dst_user = sb.own_user;
        it.pkt_dst_node = sb.own_node;
        it.crc_ok = crc;
        return it;
    endfunction

    // Mostly steer the link through its next legal step; the rest is noise.
    function automatic rtsc_pkg::item_t pick_item();
        rtsc_pkg::item_t it;
        int unsigned     roll;
        logic [7:0]      size;
        roll = $urandom_range(99);
        size = ($urandom_range(19) == 0) ? 8'($urandom_range(7)) : 8'($urandom_range(8, 255));
        if (roll < 25) begin
            it.func = 2'($urandom_range(3));
            it.rx_len = 8'($urandom);
            case ($urandom_range(5))
                0: it.rx_kind = rtsc_pkg::PKT_RTS;
                1: it.rx_kind = rtsc_pkg::PKT_CTS;
                2: it.rx_kind = rtsc_pkg::PKT_DATA;
                3: it.rx_kind = rtsc_pkg::PKT_ACK;
                4: it.rx_kind = rtsc_pkg::PKT_RETRY;
                default: it.rx_kind = 8'($urandom);
            endcase
            it.pkt_msg_id = $urandom_range(1) ? sb.own_msg_id : 8'($urandom);
            it.pkt_dst_user = $urandom_range(1) ? sb.own_user : 8'($urandom);
            it.pkt_dst_node = $urandom_range(1) ? sb.own_node : 8'($urandom);
            it.crc_ok = 1'($urandom);
            return it;
        end
        roll = $urandom_range(99);
        case (sb.phase)
            rtsc_pkg::PH_IDLE: begin
                if (roll < 35) return make_item(rtsc_pkg::FUNC_SEND);
                if (roll < 65)
                    return make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_RTS,
                                     8'($urandom), 1'b1, size);
            end
            rtsc_pkg::PH_WAIT_CTS: begin
                if (roll < 35)
                    return make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_CTS,
                                     8'($urandom), 1'b1, size);
            end
            rtsc_pkg::PH_WAIT_ACK: begin
                if (roll < 25)
                    return make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_ACK,
                                     sb.own_msg_id, 1'b1, size);
                if (roll < 40)
                    return make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_RETRY,
                                     sb.own_msg_id, 1'b1, size);
            end
            rtsc_pkg::PH_WAIT_DATA: begin
                if (roll < 30)
                    return make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_DATA, 8'($urandom),
                                     $urandom_range(99) < 80, size);
            end
            default: ;
        endcase
        return make_item(rtsc_pkg::FUNC_TICK);
    endfunction

    // Offer one item, hold it until the transaction completes, then log it.
    task automatic send_item(rtsc_pkg::item_t it);
        if (!quiet && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata <= {7'd0, it.crc_ok, it.pkt_dst_node, it.pkt_dst_user,
                    it.pkt_msg_id, it.rx_kind, it.rx_len};
        s_tuser <= it.func;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(int ph);
        case (ph)
            0: begin
                write_reg(rtsc_pkg::CFG_OWN_USER, 16'h005A);
                write_reg(rtsc_pkg::CFG_OWN_NODE, 16'h00A5);
                write_reg(rtsc_pkg::CFG_PEER_USER, 16'h0000);
                write_reg(rtsc_pkg::CFG_PEER_NODE, 16'h00FF);
                write_reg(rtsc_pkg::CFG_MAX_RETRY, 16'd0);
                write_reg(rtsc_pkg::CFG_TIMEOUT, 16'd1);
                write_reg(rtsc_pkg::CFG_COOLDOWN, 16'd0);
            end
            1: begin
                write_reg(rtsc_pkg::CFG_OWN_USER, 16'h0000);
                write_reg(rtsc_pkg::CFG_OWN_NODE, 16'h0000);
                write_reg(rtsc_pkg::CFG_MAX_RETRY, 16'd15);
                write_reg(rtsc_pkg::CFG_TIMEOUT, 16'd2);
                write_reg(rtsc_pkg::CFG_COOLDOWN, 16'd3);
            end
            2: begin
                write_reg(rtsc_pkg::CFG_OWN_USER, 16'h00FF);
                write_reg(rtsc_pkg::CFG_OWN_NODE, 16'h00FF);
                write_reg(rtsc_pkg::CFG_PEER_USER, 16'h00FF);
                write_reg(rtsc_pkg::CFG_PEER_NODE, 16'h0000);
                write_reg(rtsc_pkg::CFG_MAX_RETRY, 16'd1);
                write_reg(rtsc_pkg::CFG_TIMEOUT, 16'd1);
                write_reg(rtsc_pkg::CFG_COOLDOWN, 16'd0);
            end
            3: begin
                write_reg(rtsc_pkg::CFG_OWN_USER, 16'($urandom_range(255)));
                write_reg(rtsc_pkg::CFG_OWN_NODE, 16'($urandom_range(255)));
                write_reg(rtsc_pkg::CFG_MAX_RETRY, 16'($urandom_range(3)));
                write_reg(rtsc_pkg::CFG_TIMEOUT, 16'($urandom_range(3, 8)));
                write_reg(rtsc_pkg::CFG_COOLDOWN, 16'($urandom_range(6)));
            end
            4: begin
                write_reg(rtsc_pkg::CFG_OWN_USER, 16'($urandom_range(255)));
                write_reg(rtsc_pkg::CFG_MAX_RETRY, 16'd2);
                write_reg(rtsc_pkg::CFG_TIMEOUT, 16'hFFFF);
                write_reg(rtsc_pkg::CFG_COOLDOWN, 16'hFFFF);
            end
            default: begin
                write_reg(rtsc_pkg::CFG_OWN_NODE, 16'($urandom_range(255)));
                write_reg(rtsc_pkg::CFG_PEER_USER, 16'($urandom_range(255)));
                write_reg(rtsc_pkg::CFG_PEER_NODE, 16'($urandom_range(255)));
                write_reg(rtsc_pkg::CFG_MAX_RETRY, 16'($urandom_range(1, 4)));
                write_reg(rtsc_pkg::CFG_TIMEOUT, 16'($urandom_range(1, 12)));
                write_reg(rtsc_pkg::CFG_COOLDOWN, 16'($urandom_range(10)));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    initial begin
        rtsc_pkg::item_t it;
        int              ph;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        configure(0);

        // Directed: timeout of one tick, no retries, no cooldown.
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(FUNC_NONE));
        send_item(make_item(rtsc_pkg::FUNC_SEND));
        send_item(make_item(rtsc_pkg::FUNC_SEND));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_RTS, 8'h11, 1'b1, 8'd7));
        it = make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_RTS, 8'h22);
        it.pkt_dst_user = ~sb.own_user;
        send_item(it);
        send_item(make_item(rtsc_pkg::FUNC_PKT, 8'hFF, 8'h33, 1'b1, 8'hFF));
        send_item(make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_RTS, 8'hFF, 1'b1, 8'hFF));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_DATA, 8'h80, 1'b0));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_DATA, 8'h00, 1'b1));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_SEND));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_CTS, 8'h44));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_RETRY, sb.own_msg_id));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_ACK, sb.own_msg_id + 8'd1));
        send_item(make_item(rtsc_pkg::FUNC_PKT, rtsc_pkg::PKT_ACK, sb.own_msg_id));
        send_item(make_item(rtsc_pkg::FUNC_TICK));
        send_item(make_item(rtsc_pkg::FUNC_TICK));

        for (ph = 1; ph <= 5; ph++) begin
            settle();
            quiet = (ph == 2);
            configure(ph);
            repeat (ITEMS_PER_PHASE) send_item(pick_item());
        end
        settle();
        quiet = 0;
        repeat (8) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
